// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expands to one labeled
// concurrent assertion on the rising edge of i_clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define AEMX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define AEMX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/aemx_pkg.sv
// ----------------------------------------------------------------------------
// aemx_pkg
// Types and codes for the actuator exploration mixer.
// ----------------------------------------------------------------------------
package aemx_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_RNG_SEED     = 3'd0;
    localparam logic [2:0] CFG_PLACE_GAIN   = 3'd1;
    localparam logic [2:0] CFG_NUDGE_MAX    = 3'd2;
    localparam logic [2:0] CFG_REST_GAIN    = 3'd3;
    localparam logic [2:0] CFG_JITTER_GAIN  = 3'd4;
    localparam logic [2:0] CFG_CONT_GAIN    = 3'd5;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_SCL   = 5'b00100,
        ST_SUM   = 5'b01000,
        ST_CLAMP = 5'b10000
    } t_state;

    // Product steps of the shared multiplier, in issue order.
    typedef enum logic [3:0] {
        STP_NUDGE = 4'd0,
        STP_REST1 = 4'd1,
        STP_REST2 = 4'd2,
        STP_NZ1   = 4'd3,
        STP_NZ2   = 4'd4,
        STP_NZ3   = 4'd5,
        STP_NZ4   = 4'd6,
        STP_DIRC  = 4'd7,
        STP_BI1   = 4'd8,
        STP_BI2   = 4'd9
    } t_step;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

endpackage

// File: hdl/actuator_exploration_mixer_unit.sv
// ----------------------------------------------------------------------------
// actuator_exploration_mixer_unit
// Computes a new exploratory target for one actuator from its present value,
// its range, the drives and the learned context, using a shared multiplier.
// ----------------------------------------------------------------------------
// One beat in gives at most one beat out. The target is the baseline plus a
// pull toward zero under rest pressure, plus xorshift32 noise scaled by the
// fuzz, the range span, the noise gain and a spatial nudge factor, plus a
// direction bias weighted by confidence; the sum is clamped to the range.
// All values are signed fixed point with FRAC_BITS fraction bits; every
// product but direction times confidence is rounded toward minus infinity
// at the fraction point, and every product saturates to 32 bits. A beat
// with override set produces no result and does not advance the generator.
// Any other beat runs ten products through one 32x32 multiplier, each
// product passing through a multiply state and a scale state, then a sum
// state adds the terms and a clamp state clamps the result to the range.
// The unit takes its next beat only after it has returned to idle; the
// product chain through the single multiplier sets the time to a result.
// The result sits in an output register, so a new beat is taken while
// the previous result still waits downstream; the unit only holds in the
// clamp state if the output register is still occupied. Configuration
// writes take effect at once and must be made while the unit is idle.
// Writing the seed reloads the generator, and a seed of zero loads one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module actuator_exploration_mixer_unit
    import aemx_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    // input beat
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_baseline,
    input  logic signed [31:0] i_range_low,
    input  logic signed [31:0] i_range_high,
    input  logic               i_override_active,
    input  logic signed [7:0]  i_direction,
    input  logic [16:0]        i_confidence,
    input  logic signed [31:0] i_place_score,
    input  logic               i_at_best_place,
    input  logic [30:0]        i_fuzz,
    input  logic signed [31:0] i_fatigue_drive,
    input  logic signed [31:0] i_energy_drive,
    // result beat
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_target
);

    // One in fixed point, and the shift that maps the generator state onto
    // a noise value spanning minus one to plus one.
    localparam logic signed [31:0] QONE      = 32'sd1 <<< FRAC_BITS;
    localparam int                 NOISE_SH  = 31 - FRAC_BITS;

    // Control state.
    t_state             r_state;
    t_step              r_step;
    logic               r_out_valid;
    logic [31:0]        r_noise_state;

    // Configuration registers.
    logic [30:0]        r_place_gain;
    logic [30:0]        r_nudge_max;
    logic [30:0]        r_rest_gain;
    logic [30:0]        r_jitter_gain;
    logic [30:0]        r_cont_gain;

    // Captured beat and working values.
    logic signed [31:0] r_baseline;
    logic signed [31:0] r_lo;
    logic signed [31:0] r_hi;
    logic signed [7:0]  r_dir;
    logic [16:0]        r_conf;
    logic signed [31:0] r_best;
    logic               r_at_best;
    logic [30:0]        r_fuzz;
    logic signed [31:0] r_rest;
    logic signed [31:0] r_span;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_acc;
    logic signed [31:0] r_fac;
    logic signed [31:0] r_pull;
    logic signed [31:0] r_nterm;
    logic signed [33:0] r_sum;
    logic signed [31:0] r_target;

    logic               in_fire;
    logic               work_fire;
    logic [31:0]        xs_a;
    logic [31:0]        xs_b;
    logic [31:0]        n_noise_state;
    logic signed [31:0] noise_val;
    logic signed [32:0] drive_sum;
    logic signed [31:0] n_rest;
    logic signed [32:0] span_diff;
    logic signed [31:0] n_span;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [63:0] scl_shift;
    logic signed [31:0] scl_res;
    logic signed [31:0] nudge_mag;
    logic signed [32:0] fac_sum;
    logic signed [31:0] n_fac;
    logic signed [31:0] n_pull;
    logic signed [31:0] n_target;
    logic               out_free;

    assign o_ready   = (r_state == ST_IDLE);
    assign in_fire   = i_valid && o_ready;
    assign work_fire = in_fire && !i_override_active;
    assign o_valid   = r_out_valid;
    assign o_target  = r_target;
    assign out_free  = !r_out_valid || i_ready;

    // Generator advance: shifts of 13, 17 and 5.
    always_comb begin
        xs_a          = r_noise_state ^ (r_noise_state << 13);
        xs_b          = xs_a ^ (xs_a >> 17);
        n_noise_state = xs_b ^ (xs_b << 5);
    end

    // The noise is taken from the already advanced state, which is held in
    // r_noise_state for the whole item.
    assign noise_val = $signed(r_noise_state >> NOISE_SH) - QONE;

    // Per-beat values that need no product: rest pressure and range span.
    always_comb begin
        drive_sum = 33'(i_fatigue_drive) + 33'(i_energy_drive);
        if (drive_sum < 33'sd0) begin
            n_rest = 32'sd0;
        end else if (drive_sum > 33'(QONE)) begin
            n_rest = QONE;
        end else begin
            n_rest = 32'(drive_sum);
        end

        span_diff = 33'(i_range_high) - 33'(i_range_low);
        if (span_diff > 33'(S32_MAX)) begin
            n_span = S32_MAX;
        end else if (span_diff < 33'(S32_MIN)) begin
            n_span = S32_MIN;
        end else begin
            n_span = 32'(span_diff);
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_step)
            STP_NUDGE: begin
                op_a = r_best;
                op_b = $signed({1'b0, r_place_gain});
            end
            STP_REST1: begin
                op_a = r_baseline;
                op_b = r_rest;
            end
            STP_REST2: begin
                op_a = r_acc;
                op_b = $signed({1'b0, r_rest_gain});
            end
            STP_NZ1: begin
                op_a = noise_val;
                op_b = $signed({1'b0, r_fuzz});
            end
            STP_NZ2, STP_BI1: begin
                op_a = r_acc;
                op_b = r_span;
            end
            STP_NZ3: begin
                op_a = r_acc;
                op_b = $signed({1'b0, r_jitter_gain});
            end
            STP_NZ4: begin
                op_a = r_acc;
                op_b = r_fac;
            end
            STP_DIRC: begin
                op_a = 32'(r_dir);
                op_b = $signed({15'd0, r_conf});
            end
            STP_BI2: begin
                op_a = r_acc;
                op_b = $signed({1'b0, r_cont_gain});
            end
            default: begin
                op_a = 32'sd0;
                op_b = 32'sd0;
            end
        endcase
    end

    // Scaling of the registered product: an arithmetic shift rounds toward
    // minus infinity, then the value saturates. The direction-times-
    // confidence step is an integer product and is not rescaled.
    always_comb begin
        if (r_step == STP_DIRC) begin
            scl_shift = r_prod;
        end else begin
            scl_shift = r_prod >>> FRAC_BITS;
        end
        if (scl_shift > 64'(S32_MAX)) begin
            scl_res = S32_MAX;
        end else if (scl_shift < 64'(S32_MIN)) begin
            scl_res = S32_MIN;
        end else begin
            scl_res = 32'(scl_shift);
        end
    end

    // Spatial nudge factor: one plus or minus the clamped nudge magnitude.
    // Only a positive best score moves it off one.
    always_comb begin
        if (scl_res < 32'sd0) begin
            nudge_mag = 32'sd0;
        end else if (scl_res > $signed({1'b0, r_nudge_max})) begin
            nudge_mag = $signed({1'b0, r_nudge_max});
        end else begin
            nudge_mag = scl_res;
        end
        if (r_at_best) begin
            fac_sum = 33'(QONE) - 33'(nudge_mag);
        end else begin
            fac_sum = 33'(QONE) + 33'(nudge_mag);
        end
        if (r_best <= 32'sd0) begin
            n_fac = QONE;
        end else if (fac_sum > 33'(S32_MAX)) begin
            n_fac = S32_MAX;
        end else begin
            n_fac = 32'(fac_sum);
        end
    end

    // The pull is the negated product; the most negative value saturates.
    assign n_pull = (scl_res == S32_MIN) ? S32_MAX : -scl_res;

    // Final clamp: the low bound is checked first, so an inverted range
    // gives the low bound whenever the sum lies below it.
    always_comb begin
        if (r_sum < 34'(r_lo)) begin
            n_target = r_lo;
        end else if (r_sum > 34'(r_hi)) begin
            n_target = r_hi;
        end else begin
            n_target = 32'(r_sum);
        end
    end

    // Sequencer, generator and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_step         <= STP_NUDGE;
            r_out_valid    <= 1'b0;
            r_noise_state  <= 32'd1;
            r_place_gain   <= '0;
            r_nudge_max    <= '0;
            r_rest_gain    <= '0;
            r_jitter_gain  <= '0;
            r_cont_gain    <= '0;
        end else begin
            // A new result refills the output register in the same cycle
            // that the waiting one leaves.
            if ((r_state == ST_CLAMP) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RNG_SEED: begin
                        r_noise_state <= (i_cfg_data == 32'd0) ? 32'd1 : i_cfg_data;
                    end
                    CFG_PLACE_GAIN:   r_place_gain   <= i_cfg_data[30:0];
                    CFG_NUDGE_MAX:    r_nudge_max    <= i_cfg_data[30:0];
                    CFG_REST_GAIN:    r_rest_gain    <= i_cfg_data[30:0];
                    CFG_JITTER_GAIN:  r_jitter_gain  <= i_cfg_data[30:0];
                    CFG_CONT_GAIN:    r_cont_gain    <= i_cfg_data[30:0];
                    default: begin
                    end
                endcase
            end else if (work_fire) begin
                r_noise_state <= n_noise_state;
            end

            case (r_state)
                ST_IDLE: begin
                    if (work_fire) begin
                        r_state <= ST_MUL;
                        r_step  <= STP_NUDGE;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_SCL;
                end
                ST_SCL: begin
                    if (r_step == STP_BI2) begin
                        r_state <= ST_SUM;
                    end else begin
                        r_state <= ST_MUL;
                        r_step  <= t_step'(r_step + 4'd1);
                    end
                end
                ST_SUM: begin
                    r_state <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (work_fire) begin
            r_baseline <= i_baseline;
            r_lo       <= i_range_low;
            r_hi       <= i_range_high;
            r_dir      <= i_direction;
            r_conf     <= i_confidence;
            r_best     <= i_place_score;
            r_at_best  <= i_at_best_place;
            r_fuzz     <= i_fuzz;
            r_rest     <= n_rest;
            r_span     <= n_span;
        end

        if (r_state == ST_MUL) begin
            r_prod <= op_a * op_b;
        end

        if (r_state == ST_SCL) begin
            case (r_step)
                STP_NUDGE: r_fac   <= n_fac;
                STP_REST2: r_pull  <= n_pull;
                STP_NZ4:   r_nterm <= scl_res;
                default:   r_acc   <= scl_res;
            endcase
        end

        if (r_state == ST_SUM) begin
            r_sum <= 34'(r_baseline) + 34'(r_pull) + 34'(r_nterm) + 34'(r_acc);
        end

        if ((r_state == ST_CLAMP) && out_free) begin
            r_target <= n_target;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `AEMX_ASSERT_NOW(a_noise_nonzero, 1'b1, r_noise_state != 32'd0, "generator state is zero")
    `AEMX_ASSERT_NOW(a_valid_from_clamp, $rose(o_valid), $past(r_state == ST_CLAMP), "result without clamp")
    `AEMX_ASSERT_NXT(a_override_keeps_rng, in_fire && i_override_active && !i_cfg_we, $stable(r_noise_state) && (r_state == ST_IDLE), "override beat changed state")
    `AEMX_ASSERT_NOW(a_step_range, (r_state == ST_MUL) || (r_state == ST_SCL), r_step <= STP_BI2, "step beyond last product")

endmodule
